### rtl/core/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared widths, codes and state type for the chain table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  // Field widths.
  localparam int IDX_W  = 16;
  localparam int OP_W   = 3;
  localparam int STAT_W = 3;
  localparam int EIU_W  = 13;
  localparam int DFB_W  = 16;
  localparam int BLK_W  = 17;
  localparam int OFS_W  = 32;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Default geometry of the table.
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int BLOCK_BYTES_DEF   = 4096;

  // Entry markers.
  localparam logic [IDX_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [IDX_W-1:0] FREE_MARK = 16'h0000;

  // Register reset values.
  localparam logic [EIU_W-1:0] EIU_RESET = 13'd4096;
  localparam logic [DFB_W-1:0] DFB_RESET = 16'd2;

  // Register indexes (byte address bit 2).
  localparam logic REG_ENTRIES    = 1'b0;
  localparam logic REG_DATA_FIRST = 1'b1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd2;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd4;
  localparam logic [OP_W-1:0] OP_SEEK   = 3'd5;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_IDX  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_READ,
    S_SCAN,
    S_LINK,
    S_FREE,
    S_SEEK_CHK,
    S_SEEK_RD
  } state_t;

endpackage

`default_nettype wire

### rtl/core/fat_chain_table_engine_core.sv
// ----------------------------------------------------------------------------
// fat_chain_table_engine_core
// Allocation chain table engine: load, read, allocate, append, free chain,
// seek and free count over a table of 16-bit chain entries in one RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_strobe, and the receiver
// must take it then. busy drops in the cycle the result is shown, so the next
// item can be started right away. Every access to the table goes through one
// RAM with one write port and one registered read port. Load, and any error
// found at the start, finish in the dispatch state without a table read.
// Table entries are never cleared by reset; they must be loaded before any
// operation looks at them.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_table_engine_core
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Item input.
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [IDX_W-1:0]  in_entry_value,
  input  wire logic [OFS_W-1:0]  in_byte_offset,
  // Result output.
  output logic                   out_strobe,
  output logic [STAT_W-1:0]      out_status,
  output logic [IDX_W-1:0]       out_found_index,
  output logic [BLK_W-1:0]       out_block_number,
  output logic [EIU_W-1:0]       out_free_entries,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int AW       = $clog2(TABLE_ENTRIES);
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int RCH_NEED =
    $clog2(longint'(BLOCK_BYTES) * (longint'(TABLE_ENTRIES) + 64'sd1)) + 1;
  localparam int RCH_W    = (RCH_NEED > OFS_W) ? RCH_NEED : OFS_W + 1;

  // Configuration registers.
  logic [EIU_W-1:0] eiu_r;
  logic [DFB_W-1:0] dfb_r;

  // Sequencer and per-item registers.
  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  val_r, val_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [RCH_W-1:0]  reach_r, reach_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  found_r, found_nxt;

  // Result registers.
  logic              strobe_r, strobe_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]  res_found_r, res_found_nxt;
  logic [BLK_W-1:0]  block_r, block_nxt;
  logic [EIU_W-1:0]  nfree_r, nfree_nxt;

  // Read-after-write forwarding.
  logic              fwd_hit_r, fwd_hit_nxt;
  logic [IDX_W-1:0]  fwd_data_r, fwd_data_nxt;

  // RAM controls.
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [IDX_W-1:0]  ram_wdata, ram_q, q_eff;

  // Values for a result that completes this cycle.
  logic              finishing;
  logic [STAT_W-1:0] fin_status;
  logic [IDX_W-1:0]  fin_found;
  logic [BLK_W-1:0]  fin_block;
  logic [EIU_W-1:0]  fin_nfree;

  // Shared conditions.
  logic [CNT_W-1:0]  lim_calc;
  logic [IDX_W-1:0]  lim16;
  logic [CNT_W-1:0]  steps_inc;
  logic [RCH_W-1:0]  reach_inc, ofs_ext;
  logic              idx_end, idx_bad, got_end, got_bad;
  logic              scan_more, scan_hit, scan_find;
  logic              reach_lt, reach_inc_lt, steps_lt, steps_inc_lt;
  logic [BLK_W-1:0]  cur_block;

  // Table storage.
  fct_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // A read that met a write to the same entry sees the new value.
  assign q_eff = fwd_hit_r ? fwd_data_r : ram_q;

  // Usable entry count is the register capped at the table size.
  assign lim_calc = (32'(eiu_r) < TABLE_ENTRIES) ? CNT_W'(eiu_r) : CNT_W'(TABLE_ENTRIES);
  assign lim16    = IDX_W'(lim_r);

  assign steps_inc    = steps_r + CNT_W'(1);
  assign reach_inc    = reach_r + RCH_W'(BLOCK_BYTES);
  assign ofs_ext      = RCH_W'(ofs_r);
  assign idx_end      = (idx_r == END_MARK);
  assign idx_bad      = (idx_r >= lim16);
  assign got_end      = (q_eff == END_MARK);
  assign got_bad      = (q_eff >= lim16);
  assign scan_more    = (scan_r < lim_r);
  assign scan_hit     = pend_r && (q_eff == FREE_MARK);
  assign scan_find    = scan_hit && (op_r != OP_COUNT);
  assign reach_lt     = (reach_r < ofs_ext);
  assign reach_inc_lt = (reach_inc < ofs_ext);
  assign steps_lt     = (steps_r < lim_r);
  assign steps_inc_lt = (steps_inc < lim_r);
  assign cur_block    = BLK_W'(cur_r) + BLK_W'(dfb_r);

  assign busy = (state_r != S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          OP_READ:   state_nxt = idx_bad ? S_IDLE : S_READ;
          OP_ALLOC:  state_nxt = S_SCAN;
          OP_APPEND: state_nxt = idx_bad ? S_IDLE : S_SCAN;
          OP_COUNT:  state_nxt = S_SCAN;
          OP_FREE:   state_nxt = (idx_end || idx_bad) ? S_IDLE : S_FREE;
          OP_SEEK:   state_nxt = (idx_end || idx_bad) ? S_IDLE : S_SEEK_CHK;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_READ: state_nxt = S_IDLE;
      S_SCAN: begin
        if (scan_find) begin
          state_nxt = (op_r == OP_APPEND) ? S_LINK : S_IDLE;
        end else if (!scan_more && !pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK: state_nxt = S_IDLE;
      S_FREE: begin
        if (got_end || got_bad || !steps_inc_lt) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEEK_CHK: begin
        state_nxt = (!reach_lt || !steps_lt) ? S_IDLE : S_SEEK_RD;
      end
      S_SEEK_RD: begin
        if (got_end || got_bad) begin
          state_nxt = S_IDLE;
        end else if (!(reach_inc_lt && steps_inc_lt)) begin
          state_nxt = S_SEEK_CHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result values.
  always_comb begin
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ofs_nxt       = ofs_r;
    lim_nxt       = lim_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    reach_nxt     = reach_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];
    fin_status    = STAT_OK;
    fin_found     = '0;
    fin_block     = '0;
    fin_nfree     = '0;
    case (state_r)
      // Capture the item.
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_op;
          idx_nxt = in_entry_index;
          val_nxt = in_entry_value;
          ofs_nxt = in_byte_offset;
          lim_nxt = lim_calc;
        end
      end
      // Check the index and set up the operation.
      S_DISP: begin
        pend_nxt = 1'b0;
        case (op_r)
          OP_LOAD: begin
            if (idx_bad) begin
              fin_status = STAT_BAD_IDX;
            end else begin
              ram_we    = 1'b1;
              fin_found = idx_r;
            end
          end
          OP_READ: begin
            if (idx_bad) begin
              fin_status = STAT_BAD_IDX;
            end else begin
              ram_re = 1'b1;
            end
          end
          OP_ALLOC: begin
            scan_nxt = CNT_W'(1);
          end
          OP_APPEND: begin
            scan_nxt = CNT_W'(1);
            if (idx_bad) begin
              fin_status = STAT_BAD_IDX;
            end
          end
          OP_COUNT: begin
            scan_nxt = '0;
            cnt_nxt  = '0;
          end
          OP_FREE: begin
            cur_nxt   = idx_r;
            steps_nxt = '0;
            if (idx_end) begin
              fin_status = STAT_EMPTY;
            end else if (idx_bad) begin
              fin_status = STAT_BAD_IDX;
            end else begin
              ram_re = 1'b1;
            end
          end
          OP_SEEK: begin
            cur_nxt   = idx_r;
            steps_nxt = '0;
            reach_nxt = RCH_W'(BLOCK_BYTES - 1);
            if (idx_end) begin
              fin_status = STAT_EMPTY;
            end else if (idx_bad) begin
              fin_status = STAT_BAD_IDX;
            end
          end
          default: begin
            fin_status = STAT_OK;
          end
        endcase
      end
      S_READ: begin
        fin_found = q_eff;
      end
      // Streaming scan: one read issued and one entry checked per cycle.
      S_SCAN: begin
        if (scan_find) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r;
          ram_wdata = END_MARK;
          found_nxt = IDX_W'(pend_addr_r);
          fin_found = IDX_W'(pend_addr_r);
          pend_nxt  = 1'b0;
        end else begin
          if (scan_hit) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (scan_more) begin
            ram_re        = 1'b1;
            ram_raddr     = scan_r[AW-1:0];
            pend_nxt      = 1'b1;
            pend_addr_nxt = scan_r[AW-1:0];
            scan_nxt      = scan_r + CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
          end
          if (!scan_more && !pend_r) begin
            if (op_r == OP_COUNT) begin
              fin_nfree = EIU_W'(cnt_r);
            end else begin
              fin_status = STAT_NO_FREE;
            end
          end
        end
      end
      // Link the chain tail to the new entry.
      S_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = found_r;
        fin_found = found_r;
      end
      // Free one entry per cycle and fetch its successor.
      S_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r[AW-1:0];
        ram_wdata = FREE_MARK;
        if (got_end) begin
          fin_status = STAT_OK;
        end else if (got_bad) begin
          fin_status = STAT_BAD_IDX;
        end else if (!steps_inc_lt) begin
          fin_status = STAT_TOO_LONG;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = q_eff[AW-1:0];
          cur_nxt   = q_eff;
          steps_nxt = steps_inc;
        end
      end
      // Decide whether the walk goes on from the current entry.
      S_SEEK_CHK: begin
        if (!reach_lt) begin
          fin_found = cur_r;
          fin_block = cur_block;
        end else if (!steps_lt) begin
          fin_status = STAT_TOO_LONG;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_r[AW-1:0];
        end
      end
      // Follow one link per cycle while both limits allow another hop.
      S_SEEK_RD: begin
        if (got_end) begin
          fin_found = cur_r;
          fin_block = cur_block;
        end else if (got_bad) begin
          fin_status = STAT_BAD_IDX;
        end else begin
          cur_nxt   = q_eff;
          reach_nxt = reach_inc;
          steps_nxt = steps_inc;
          if (reach_inc_lt && steps_inc_lt) begin
            ram_re    = 1'b1;
            ram_raddr = q_eff[AW-1:0];
          end
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Result capture.
  assign finishing     = (state_r != S_IDLE) && (state_nxt == S_IDLE);
  assign strobe_nxt    = finishing;
  assign status_nxt    = finishing ? fin_status : status_r;
  assign res_found_nxt = finishing ? fin_found : res_found_r;
  assign block_nxt     = finishing ? fin_block : block_r;
  assign nfree_nxt     = finishing ? fin_nfree : nfree_r;

  // Forwarding capture.
  assign fwd_hit_nxt  = ram_we && ram_re && (ram_raddr == ram_waddr);
  assign fwd_data_nxt = ram_wdata;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      strobe_r  <= 1'b0;
      pend_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
      eiu_r     <= EIU_RESET;
      dfb_r     <= DFB_RESET;
    end else begin
      state_r   <= state_nxt;
      strobe_r  <= strobe_nxt;
      pend_r    <= pend_nxt;
      fwd_hit_r <= fwd_hit_nxt;
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_ENTRIES:    eiu_r <= pwdata[EIU_W-1:0];
          REG_DATA_FIRST: dfb_r <= pwdata[DFB_W-1:0];
          default:        eiu_r <= eiu_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    ofs_r       <= ofs_nxt;
    lim_r       <= lim_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    reach_r     <= reach_nxt;
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    cnt_r       <= cnt_nxt;
    found_r     <= found_nxt;
    fwd_data_r  <= fwd_data_nxt;
    status_r    <= status_nxt;
    res_found_r <= res_found_nxt;
    block_r     <= block_nxt;
    nfree_r     <= nfree_nxt;
  end

  // Register readback.
  assign prdata = paddr[2] ? APB_DW'(dfb_r) : APB_DW'(eiu_r);
  assign pready = 1'b1;

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_found_index  = res_found_r;
  assign out_block_number = block_r;
  assign out_free_entries = nfree_r;

  // A result is only produced at the end of an item.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r != S_IDLE))
    else $error("result strobe without an item in progress");

  // Results are single-cycle pulses.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // Simultaneous read and write only happen while freeing a chain.
  a_rw_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (state_r == S_FREE))
    else $error("unexpected concurrent table read and write");

  // A pending scan read always targets a usable entry.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && state_r == S_SCAN) |-> (IDX_W'(pend_addr_r) < lim16))
    else $error("scan read beyond the usable entries");

endmodule

`default_nettype wire

### rtl/core/fct_ram.sv
// ----------------------------------------------------------------------------
// fct_ram
// Generic single-write, single-read RAM with a registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### tb/tb_fat_chain_table_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat_chain_table_engine_core
// Self-checking bench for the chain table engine. A clocked driver offers
// items from a queue and mirrors each accepted item in a local table model.
// A clocked monitor compares every result strobe, field by field, against
// the oldest predicted answer. The whole table is loaded first, then a
// directed pass runs, then random chains, appends, fills and noise follow
// under a sweep of register settings.
// ----------------------------------------------------------------------------

module tb_fat_chain_table_engine_core;
  import fct_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int BLOCK_BYTES   = BLOCK_BYTES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] val;
    logic [OFS_W-1:0] ofs;
  } fat_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found;
    logic [BLK_W-1:0]  block;
    logic [EIU_W-1:0]  nfree;
  } fat_ans_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_op = '0;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [IDX_W-1:0]  in_entry_value = '0;
  logic [OFS_W-1:0]  in_byte_offset = '0;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_found_index;
  logic [BLK_W-1:0]  out_block_number;
  logic [EIU_W-1:0]  out_free_entries;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Local copy of the table and the two registers.
  logic [IDX_W-1:0] fat_mirror [TABLE_ENTRIES];
  logic [EIU_W-1:0] eiu_q = EIU_RESET;
  logic [DFB_W-1:0] dfb_q = DFB_RESET;

  fat_cmd_t    op_q [$];
  fat_ans_t    answer_q [$];
  fat_cmd_t    cur_cmd;
  fat_ans_t    last_answer;
  int unsigned n_issued = 0;
  int unsigned n_done = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_pct = 35;

  fat_chain_table_engine_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_byte_offset   (in_byte_offset),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_found_index  (out_found_index),
    .out_block_number (out_block_number),
    .out_free_entries (out_free_entries),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Number of entries the engine may touch under the current setting.
  function automatic int unsigned usable_entries();
    return (eiu_q < TABLE_ENTRIES) ? eiu_q : TABLE_ENTRIES;
  endfunction

  // Takes the first free entry from index 1 and marks it end of chain.
  function automatic bit grab_free(input int unsigned lim, output logic [IDX_W-1:0] got);
    got = '0;
    for (int unsigned i = 1; i < lim; i++) begin
      if (fat_mirror[i] == FREE_MARK) begin
        fat_mirror[i] = END_MARK;
        got = IDX_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one item to the mirrored table and returns the answer it gives.
  function automatic fat_ans_t chain_table_step(input fat_cmd_t c);
    fat_ans_t         a;
    int unsigned      lim;
    int unsigned      steps;
    int unsigned      n;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] got;
    logic [63:0]      reach;
    bit               walking;
    a = '0;
    lim = usable_entries();
    idx = c.idx;
    n = 0;
    case (c.op)
      OP_LOAD: begin
        if (idx < lim) begin
          fat_mirror[idx] = c.val;
          a.found = idx;
        end else begin
          a.status = STAT_BAD_IDX;
        end
      end
      OP_READ: begin
        if (idx < lim) a.found = fat_mirror[idx];
        else a.status = STAT_BAD_IDX;
      end
      OP_ALLOC: begin
        if (grab_free(lim, got)) a.found = got;
        else a.status = STAT_NO_FREE;
      end
      OP_APPEND: begin
        if (idx >= lim) begin
          a.status = STAT_BAD_IDX;
        end else if (!grab_free(lim, got)) begin
          a.status = STAT_NO_FREE;
        end else begin
          fat_mirror[idx] = got;
          a.found = got;
        end
      end
      OP_FREE: begin
        // Entries freed before a bad link or an overlong walk stay freed.
        if (idx == END_MARK) begin
          a.status = STAT_EMPTY;
        end else begin
          steps = 0;
          while (idx != END_MARK && a.status == STAT_OK) begin
            if (idx >= lim) begin
              a.status = STAT_BAD_IDX;
            end else if (steps >= lim) begin
              a.status = STAT_TOO_LONG;
            end else begin
              got = fat_mirror[idx];
              fat_mirror[idx] = FREE_MARK;
              idx = got;
              steps++;
            end
          end
        end
      end
      OP_SEEK: begin
        if (idx == END_MARK) begin
          a.status = STAT_EMPTY;
        end else if (idx >= lim) begin
          a.status = STAT_BAD_IDX;
        end else begin
          // Hop until the block covers the offset or the chain ends.
          reach = 64'(BLOCK_BYTES - 1);
          steps = 0;
          walking = 1'b1;
          while (walking && reach < 64'(c.ofs)) begin
            if (steps >= lim) begin
              a.status = STAT_TOO_LONG;
              walking = 1'b0;
            end else begin
              got = fat_mirror[idx];
              if (got == END_MARK) begin
                walking = 1'b0;
              end else if (got >= lim) begin
                a.status = STAT_BAD_IDX;
                walking = 1'b0;
              end else begin
                idx = got;
                reach += 64'(BLOCK_BYTES);
                steps++;
              end
            end
          end
          if (a.status == STAT_OK) begin
            a.found = idx;
            a.block = {1'b0, idx} + {1'b0, dfb_q};
          end
        end
      end
      OP_COUNT: begin
        for (int unsigned i = 0; i < lim; i++) begin
          if (fat_mirror[i] == FREE_MARK) n++;
        end
        a.nfree = EIU_W'(n);
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // Byte offset for a seek over a chain of the given length.
  function automatic logic [OFS_W-1:0] pick_offset(input int unsigned hops);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return OFS_W'($urandom_range(0, (hops + 1) * BLOCK_BYTES - 1));
    if (r < 75) return OFS_W'($urandom_range(1, hops + 1) * BLOCK_BYTES - $urandom_range(0, 1));
    return OFS_W'($urandom);
  endfunction

  task automatic post_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [IDX_W-1:0] val, input logic [OFS_W-1:0] ofs);
    fat_cmd_t c;
    c.op = op;
    c.idx = idx;
    c.val = val;
    c.ofs = ofs;
    op_q.push_back(c);
    n_issued++;
  endtask

  // Waits until every posted item has returned its result.
  task automatic settle();
    while (n_done < n_issued) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Reads a register back and compares it with the local copy.
  task automatic reg_read(input logic sel);
    logic [APB_DW-1:0] want;
    want = (sel == REG_ENTRIES) ? APB_DW'(eiu_q) : APB_DW'(dfb_q);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(sel == REG_ENTRIES ? "entries_in_use" : "data_first_block", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic sel, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_ENTRIES) eiu_q = data[EIU_W-1:0];
    else dfb_q = data[DFB_W-1:0];
    reg_read(sel);
  endtask

  // Item driver: predicts each accepted item, then offers the next one.
  always @(posedge clk) begin : drive_items
    logic offer;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      offer = start;
      if (start && !busy) begin
        last_answer = chain_table_step(cur_cmd);
        answer_q.push_back(last_answer);
        offer = 1'b0;
      end
      if (!offer && op_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur_cmd = op_q.pop_front();
        in_op          <= cur_cmd.op;
        in_entry_index <= cur_cmd.idx;
        in_entry_value <= cur_cmd.val;
        in_byte_offset <= cur_cmd.ofs;
        offer = 1'b1;
      end
      start <= offer;
    end
  end

  // Result monitor: every strobe must match the oldest predicted answer.
  always @(posedge clk) begin : check_results
    fat_ans_t want;
    if (rst_n && out_strobe) begin
      n_done++;
      if (answer_q.size() == 0) begin
        $error("result strobe with no item outstanding");
        fail_cnt++;
      end else begin
        want = answer_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("found_index", 32'(want.found), 32'(out_found_index));
        check_field("block_number", 32'(want.block), 32'(out_block_number));
        check_field("free_entries", 32'(want.nfree), 32'(out_free_entries));
      end
    end
  end

  initial begin : stimulus
    int unsigned      lim;
    int unsigned      k;
    int unsigned      r;
    int unsigned      j;
    int unsigned      p;
    int unsigned      ph_len;
    int unsigned      phase_start;
    int unsigned      rand_base;
    logic [EIU_W-1:0] eiu_v;
    logic [DFB_W-1:0] dfb_v;
    logic [IDX_W-1:0] links [8];
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] v;
    logic [OP_W-1:0]  op;
    bit               dup;

    foreach (fat_mirror[i]) fat_mirror[i] = FREE_MARK;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers must come out of reset at their defaults.
    reg_read(REG_ENTRIES);
    reg_read(REG_DATA_FIRST);

    // Every entry gets a defined value before anything scans the table.
    for (j = 0; j < TABLE_ENTRIES; j++) begin
      post_item(OP_LOAD, IDX_W'(j), FREE_MARK, OFS_W'($urandom));
    end

    // Directed pass at the reset setting: full table, data start at 2.
    post_item(OP_LOAD, END_MARK, END_MARK, '0);
    post_item(OP_READ, IDX_W'(TABLE_ENTRIES), '0, '0);
    post_item(OP_READ, IDX_W'(TABLE_ENTRIES - 1), '0, '0);
    post_item(OP_COUNT, '0, '0, '0);
    post_item(OP_ALLOC, '0, '0, '0);
    post_item(OP_APPEND, 16'd1, '0, '0);
    post_item(OP_APPEND, END_MARK, '0, '0);
    post_item(OP_SEEK, 16'd1, '0, '0);
    post_item(OP_SEEK, 16'd1, '0, OFS_W'(BLOCK_BYTES));
    // Offset far past the chain: the walk stops on the last entry.
    post_item(OP_SEEK, 16'd1, '0, '1);
    post_item(OP_SEEK, END_MARK, '0, '0);
    post_item(OP_FREE, END_MARK, '0, '0);
    post_item(OP_SEEK, IDX_W'(TABLE_ENTRIES), '0, '0);
    post_item(OP_READ, 16'd1, '0, '0);
    // A self-linked entry makes both walks run too long.
    post_item(OP_LOAD, 16'd5, 16'd5, '0);
    post_item(OP_SEEK, 16'd5, '0, '1);
    post_item(OP_FREE, 16'd5, '0, '0);
    // A chain whose last link points outside the table.
    post_item(OP_LOAD, 16'd6, 16'd7, '0);
    post_item(OP_LOAD, 16'd7, IDX_W'(TABLE_ENTRIES), '0);
    post_item(OP_FREE, 16'd6, '0, '0);
    post_item(OP_FREE, 16'd1, '0, '0);
    post_item(OP_UNUSED, '1, '1, '1);
    post_item(OP_LOAD, 16'd3, END_MARK, '0);
    post_item(OP_READ, 16'd3, '0, '0);
    post_item(OP_COUNT, '0, '0, '0);
    settle();

    // Random part over a sweep of register settings.
    rand_base = n_issued;
    for (p = 0; p < 10; p++) begin
      case (p)
        0: begin eiu_v = 13'd16;   dfb_v = 16'd0;     ph_len = 250; end
        1: begin eiu_v = 13'd1;    dfb_v = 16'hFFFF;  ph_len = 60;  end
        2: begin eiu_v = 13'd0;    dfb_v = 16'd1234;  ph_len = 40;  end
        3: begin eiu_v = 13'd64;   dfb_v = DFB_W'($urandom); ph_len = 300; end
        4: begin eiu_v = 13'd4096; dfb_v = 16'hFFFF;  ph_len = 60;  end
        5: begin eiu_v = 13'd8191; dfb_v = 16'd7;     ph_len = 30;  end
        6: begin eiu_v = 13'd5000; dfb_v = 16'd2;     ph_len = 30;  end
        7: begin eiu_v = 13'd24;   dfb_v = 16'd40000; ph_len = 300; end
        8: begin eiu_v = 13'd200;  dfb_v = 16'd0;     ph_len = 250; end
        default: begin eiu_v = 13'd8; dfb_v = 16'hFFFF; ph_len = 330; end
      endcase
      settle();
      reg_write(REG_ENTRIES, APB_DW'(eiu_v));
      reg_write(REG_DATA_FIRST, APB_DW'(dfb_v));
      lim = usable_entries();
      phase_start = n_issued;

      while (n_issued - phase_start < ph_len) begin
        // Sender gaps: moderate, then heavy, then none.
        if (n_issued - rand_base < 550) idle_pct = 35;
        else if (n_issued - rand_base < 1100) idle_pct = 63;
        else idle_pct = 0;

        r = $urandom_range(0, 99);
        // With no usable entry only noise makes sense.
        if (lim == 0) r = 99;

        if (r < 40) begin
          // Chain built by loads, mostly well formed, then walked.
          k = $urandom_range(1, (lim < 6) ? lim : 6);
          for (j = 0; j < k; j++) begin
            do begin
              links[j] = IDX_W'($urandom_range(0, lim - 1));
              dup = 1'b0;
              for (int unsigned q = 0; q < j; q++) begin
                if (links[q] == links[j]) dup = 1'b1;
              end
            end while (dup);
          end
          r = $urandom_range(0, 99);
          if (r < 85) tail = END_MARK;
          else if (r < 93) tail = IDX_W'($urandom_range(lim, 65534));
          else tail = links[0];
          for (j = 0; j < k; j++) begin
            post_item(OP_LOAD, links[j], (j + 1 < k) ? links[j + 1] : tail, OFS_W'($urandom));
          end
          for (j = $urandom_range(1, 3); j > 0; j--) begin
            head = ($urandom_range(0, 3) == 0) ? links[$urandom_range(0, k - 1)] : links[0];
            post_item(OP_SEEK, head, IDX_W'($urandom), pick_offset(k));
          end
          post_item(OP_READ, links[$urandom_range(0, k - 1)], IDX_W'($urandom),
                    OFS_W'($urandom));
          if ($urandom_range(0, 1) == 1) begin
            post_item(OP_FREE, links[0], IDX_W'($urandom), OFS_W'($urandom));
          end
        end else if (r < 58) begin
          // Chain grown by allocate and append, then walked.
          post_item(OP_ALLOC, IDX_W'($urandom), IDX_W'($urandom), OFS_W'($urandom));
          settle();
          if (last_answer.status == STAT_OK) begin
            head = last_answer.found;
            tail = head;
            k = 1;
            for (j = $urandom_range(1, 5); j > 0; j--) begin
              post_item(OP_APPEND, tail, IDX_W'($urandom), OFS_W'($urandom));
              settle();
              if (last_answer.status != STAT_OK) break;
              tail = last_answer.found;
              k++;
            end
            post_item(OP_SEEK, head, IDX_W'($urandom), pick_offset(k));
            post_item(OP_SEEK, head, IDX_W'($urandom), pick_offset(k));
            if ($urandom_range(0, 1) == 1) begin
              post_item(OP_FREE, head, IDX_W'($urandom), OFS_W'($urandom));
            end
          end
        end else if (r < 66 && lim <= 64) begin
          // Allocate until the table is full, count, then release a few.
          for (j = 0; j <= lim; j++) begin
            post_item(OP_ALLOC, IDX_W'($urandom), IDX_W'($urandom), OFS_W'($urandom));
            settle();
            if (last_answer.status != STAT_OK) break;
          end
          post_item(OP_COUNT, IDX_W'($urandom), IDX_W'($urandom), OFS_W'($urandom));
          for (j = $urandom_range(1, 4); j > 0; j--) begin
            post_item(OP_LOAD, IDX_W'($urandom_range(0, lim - 1)), FREE_MARK,
                      OFS_W'($urandom));
          end
        end else if (r < 72) begin
          // Free count, kept rare on large tables since it scans them whole.
          if (lim <= 256 || $urandom_range(0, 9) == 0) begin
            post_item(OP_COUNT, IDX_W'($urandom), IDX_W'($urandom), OFS_W'($urandom));
          end
          post_item(OP_READ, IDX_W'($urandom_range(0, lim - 1)), IDX_W'($urandom),
                    OFS_W'($urandom));
          post_item(OP_READ, IDX_W'($urandom_range(0, lim - 1)), IDX_W'($urandom),
                    OFS_W'($urandom));
        end else begin
          // Noise: any op with indexes at and around the table edge.
          for (j = $urandom_range(1, 4); j > 0; j--) begin
            op = OP_W'($urandom_range(0, 7));
            if (op == OP_COUNT && lim > 256 && $urandom_range(0, 9) != 0) op = OP_READ;
            case ($urandom_range(0, 4))
              0: v = IDX_W'($urandom);
              1: v = END_MARK;
              2: v = IDX_W'(lim);
              3: v = IDX_W'(lim - 1);
              default: v = (lim > 0) ? IDX_W'($urandom_range(0, lim - 1)) : IDX_W'($urandom);
            endcase
            post_item(op, v, ($urandom_range(0, 3) == 0) ? END_MARK : IDX_W'($urandom),
                      ($urandom_range(0, 1) == 1) ? OFS_W'($urandom) : pick_offset(4));
          end
        end
      end
    end

    // Drain, then leave room for any stray strobe to show up.
    settle();
    repeat (64) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop in case the engine hangs.
  initial begin : watchdog
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
rtl/core/fct_pkg.sv
rtl/core/fct_ram.sv
rtl/core/fat_chain_table_engine_core.sv
tb/tb_fat_chain_table_engine_core.sv
